>>> design/double_ended_priority_queue_core_defines.svh
// Assertion macros shared by the checker of the priority queue core
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dpq_pkg.sv
// Shared types and constants of the double-ended priority queue
`timescale 1ns / 1ps
`default_nettype none
package dpq_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int COUNT_BITS_DEF = 16;
	localparam int VALUE_W        = 32;
	localparam int OP_W           = 2;

	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP_MIN = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_MAX = 2'd2;

	localparam logic signed [VALUE_W-1:0] NEG_ONE = -32'sd1;

	typedef struct packed {
		logic                      overflowed;
		logic                      was_empty;
		logic signed [VALUE_W-1:0] popped_value;
	} result_t;

endpackage
`default_nettype wire

>>> design/dpq_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module dpq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> design/dpq_seq.sv
// Sequencer and compare unit: binary search, shift, count update over one RAM
`timescale 1ns / 1ps
`default_nettype none
module dpq_seq #(
	parameter int CAPACITY   = dpq_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = dpq_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      in_valid,
	output logic                                           in_ready,
	input  wire logic [dpq_pkg::OP_W-1:0]                  in_op,
	input  wire logic signed [dpq_pkg::VALUE_W-1:0]        in_value,
	output logic                                           res_valid,
	input  wire logic                                      res_ready,
	output dpq_pkg::result_t                               res,
	output logic                                           ram_wr_en,
	output logic [$clog2(CAPACITY)-1:0]                    ram_wr_addr,
	output logic [dpq_pkg::VALUE_W+COUNT_BITS-1:0]         ram_wr_data,
	output logic                                           ram_rd_en,
	output logic [$clog2(CAPACITY)-1:0]                    ram_rd_addr,
	input  wire logic [dpq_pkg::VALUE_W+COUNT_BITS-1:0]    ram_rd_data
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int OCC_W  = $clog2(CAPACITY + 1);
	localparam int DATA_W = dpq_pkg::VALUE_W + COUNT_BITS;
	localparam logic [OCC_W:0]        CAP_EXT = (OCC_W + 1)'(CAPACITY);
	localparam logic [OCC_W-1:0]      CAP_OCC = OCC_W'(CAPACITY);
	localparam logic [OCC_W-1:0]      OCC_ONE = OCC_W'(1);
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SRCH   = 4'd1;
	localparam logic [3:0] S_SCMP   = 4'd2;
	localparam logic [3:0] S_PROBE  = 4'd3;
	localparam logic [3:0] S_PCMP   = 4'd4;
	localparam logic [3:0] S_NEW    = 4'd5;
	localparam logic [3:0] S_SHIFT  = 4'd6;
	localparam logic [3:0] S_PLACE  = 4'd7;
	localparam logic [3:0] S_POPUPD = 4'd8;
	localparam logic [3:0] S_RESP   = 4'd9;

	logic [3:0]                         state_q, state_d;
	logic [dpq_pkg::OP_W-1:0]           op_q, op_d;
	logic signed [dpq_pkg::VALUE_W-1:0] val_q, val_d;
	logic [OCC_W-1:0]                   lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
	logic [OCC_W-1:0]                   occ_q, occ_d;
	logic [IDX_W-1:0]                   base_q, base_d;
	dpq_pkg::result_t                   res_q, res_d;

	logic [OCC_W-1:0]                   rd_log, wr_log, mid;
	logic signed [dpq_pkg::VALUE_W-1:0] rd_val;
	logic [COUNT_BITS-1:0]              rd_cnt;
	logic                               rd_less;

	// Map a position in value order onto the ring held in RAM
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
			input logic [OCC_W-1:0] l);
		logic [OCC_W:0] s;
		s = (OCC_W + 1)'(b) + (OCC_W + 1)'(l);
		if (s >= CAP_EXT) begin
			s = s - CAP_EXT;
		end
		return s[IDX_W-1:0];
	endfunction

	assign rd_val  = ram_rd_data[DATA_W-1:COUNT_BITS];
	assign rd_cnt  = ram_rd_data[COUNT_BITS-1:0];
	assign rd_less = rd_val < val_q;
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);

	assign ram_rd_addr = phys(base_q, rd_log);
	assign ram_wr_addr = phys(base_q, wr_log);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		val_d       = val_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		idx_d       = idx_q;
		occ_d       = occ_q;
		base_d      = base_q;
		res_d       = res_q;
		ram_rd_en   = 1'b0;
		rd_log      = '0;
		ram_wr_en   = 1'b0;
		wr_log      = '0;
		ram_wr_data = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d  = in_op;
					val_d = in_value;
					res_d = '0;
					case (in_op)
						dpq_pkg::OP_INSERT: begin
							lo_d    = '0;
							hi_d    = occ_q;
							state_d = S_SRCH;
						end
						dpq_pkg::OP_POP_MIN, dpq_pkg::OP_POP_MAX: begin
							if (occ_q == '0) begin
								res_d.popped_value = dpq_pkg::NEG_ONE;
								res_d.was_empty    = 1'b1;
								state_d            = S_RESP;
							end else begin
								idx_d     = (in_op == dpq_pkg::OP_POP_MIN) ? '0 : occ_q - OCC_ONE;
								ram_rd_en = 1'b1;
								rd_log    = idx_d;
								state_d   = S_POPUPD;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					ram_rd_en = 1'b1;
					rd_log    = mid;
					idx_d     = mid;
					state_d   = S_SCMP;
				end else begin
					state_d = S_PROBE;
				end
			end
			S_SCMP: begin
				if (rd_less) begin
					lo_d = idx_q + OCC_ONE;
				end else begin
					hi_d = idx_q;
				end
				state_d = S_SRCH;
			end
			S_PROBE: begin
				if (lo_q < occ_q) begin
					ram_rd_en = 1'b1;
					rd_log    = lo_q;
					state_d   = S_PCMP;
				end else begin
					state_d = S_NEW;
				end
			end
			S_PCMP: begin
				if (rd_val == val_q) begin
					if (&rd_cnt) begin
						res_d.overflowed = 1'b1;
					end else begin
						ram_wr_en   = 1'b1;
						wr_log      = lo_q;
						ram_wr_data = {rd_val, rd_cnt + CNT_ONE};
					end
					state_d = S_RESP;
				end else begin
					state_d = S_NEW;
				end
			end
			S_NEW: begin
				if (occ_q == CAP_OCC) begin
					res_d.overflowed = 1'b1;
					state_d          = S_RESP;
				end else if (occ_q > lo_q) begin
					idx_d     = occ_q - OCC_ONE;
					ram_rd_en = 1'b1;
					rd_log    = idx_d;
					state_d   = S_SHIFT;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_SHIFT: begin
				// write back the entry read last cycle one place up, fetch the next one down
				ram_wr_en   = 1'b1;
				wr_log      = idx_q + OCC_ONE;
				ram_wr_data = ram_rd_data;
				if (idx_q > lo_q) begin
					idx_d     = idx_q - OCC_ONE;
					ram_rd_en = 1'b1;
					rd_log    = idx_d;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				ram_wr_en   = 1'b1;
				wr_log      = lo_q;
				ram_wr_data = {val_q, CNT_ONE};
				occ_d       = occ_q + OCC_ONE;
				state_d     = S_RESP;
			end
			S_POPUPD: begin
				res_d.popped_value = rd_val;
				if (rd_cnt > CNT_ONE) begin
					ram_wr_en   = 1'b1;
					wr_log      = idx_q;
					ram_wr_data = {rd_val, rd_cnt - CNT_ONE};
				end else begin
					occ_d = occ_q - OCC_ONE;
					// drop the smallest entry by advancing the ring base
					if (op_q == dpq_pkg::OP_POP_MIN) begin
						base_d = phys(base_q, OCC_ONE);
					end
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			base_q  <= base_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		val_q <= val_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		idx_q <= idx_d;
		res_q <= res_d;
	end

endmodule
`default_nettype wire

>>> design/double_ended_priority_queue_core.sv
// Top level of the double-ended priority queue: sequencer, RAM and result register
//
// Input beats on s_*: s_tuser carries the operation (insert, pop smallest, pop
// largest; code 3 does nothing), s_tdata the value to insert. Every input beat
// gives exactly one result beat on m_*: m_tdata the popped value (-1 on an
// empty store, 0 for inserts), m_tuser the empty and overflow flags.
// Values sit in ascending order in a ring of CAPACITY entries in one RAM, each
// with a repeat count of COUNT_BITS bits.
// Work per input beat: pop: one RAM read, then a count update or removal;
//   an empty pop or a no-op goes straight to the result; insert: a binary
//   search (at most ceil(log2(n+1)) steps with n entries stored), a probe of
//   the found position p, then a count update, a dropped insert, or a shift
//   of entries p..n-1 one place up and a write of the new value at p.
// The single RAM read and write port and the one compare unit make the work
// serial; s_tready stays low while an item is worked on.
// A finished result waits in the output register while m_tready is low; the
// sequencer then holds its result and takes no further beat until it moves.
// Reset empties the store at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_priority_queue_core #(
	parameter int CAPACITY   = dpq_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = dpq_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] value
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] popped_value
	output logic [1:0]       m_tuser   // [0] was_empty, [1] overflowed
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int DATA_W = dpq_pkg::VALUE_W + COUNT_BITS;

	logic              res_valid, res_ready, slot_free;
	dpq_pkg::result_t  res, out_q;
	logic              out_valid_q;
	logic              ram_wr_en, ram_rd_en;
	logic [IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
	logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

	dpq_seq #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (s_tuser),
		.in_value    ($signed(s_tdata)),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data)
	);

	dpq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign slot_free = !out_valid_q || m_tready;
	assign res_ready = slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.popped_value;
	assign m_tuser  = {out_q.overflowed, out_q.was_empty};

endmodule
`default_nettype wire

>>> design/dpq_checker.sv
// Port-level checker of the priority queue core and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_priority_queue_core_defines.svh"
module dpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// one item at a time: the input side closes after each beat
	`DPQ_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// a new result only ever appears as the sequencer returns to idle
	`DPQ_ASSERT_NOW(a_result_then_idle, $rose(m_tvalid), s_tready, "result without idle")

	// an empty pop reports minus one
	`DPQ_ASSERT_NOW(a_empty_value, m_tvalid && m_tuser[0], m_tdata == 32'hFFFF_FFFF, "bad empty value")

	// a stalled result beat holds
	`DPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind double_ended_priority_queue_core dpq_checker u_dpq_checker (.*);
`default_nettype wire
